// ===== hdl/icd_pkg.sv =====
// Shared types and constants for the IOMMU command decoder.
// Depends on nothing; every other file of the decoder imports it.
package icd_pkg;

  localparam int unsigned WordW     = 64;
  localparam int unsigned OpcodeW   = 7;
  localparam int unsigned Func3W    = 3;
  localparam int unsigned FlagsW    = 7;
  localparam int unsigned SmallIdW  = 20;
  localparam int unsigned LargeIdW  = 16;
  localparam int unsigned SegmentW  = 8;
  localparam int unsigned FenceDataW = 32;
  localparam int unsigned KindW     = 3;
  localparam int unsigned InDataW   = 128;
  localparam int unsigned OutDataW  = 152;

  // Opcodes in bits 6:0 of the first command word.
  localparam logic [OpcodeW-1:0] OpTinval = 7'd1;
  localparam logic [OpcodeW-1:0] OpFence  = 7'd2;
  localparam logic [OpcodeW-1:0] OpDir    = 7'd3;
  localparam logic [OpcodeW-1:0] OpAts    = 7'd4;

  // Function codes in bits 9:7.
  localparam logic [Func3W-1:0] F3First  = 3'd0;
  localparam logic [Func3W-1:0] F3Second = 3'd1;

  // Command group selected by the opcode.
  typedef enum logic [2:0] {
    CLS_NONE,
    CLS_TINVAL,
    CLS_FENCE,
    CLS_DIR,
    CLS_ATS
  } cmd_class_e;

  // Decoded command kind as delivered on the result stream.
  typedef enum logic [KindW-1:0] {
    KIND_VMA       = 3'd0,
    KIND_GVMA      = 3'd1,
    KIND_INVAL_DDT = 3'd2,
    KIND_INVAL_PDT = 3'd3,
    KIND_FENCE     = 3'd4,
    KIND_ATS_INVAL = 3'd5,
    KIND_ATS_PRGR  = 3'd6,
    KIND_ILLEGAL   = 3'd7
  } kind_e;

  // First-stage decode summary.
  typedef struct packed {
    cmd_class_e        cls;
    logic [Func3W-1:0] f3;
    logic              rsv_ok;   // all reserved bits of this group are zero
    logic              rule_ok;  // func3 and operand rules hold
    logic              wis;      // fence wired interrupt request bit
  } dec_t;

  // Result fields of one command.
  typedef struct packed {
    kind_e                 kind;
    logic [FlagsW-1:0]     flags;
    logic [SmallIdW-1:0]   small_id;
    logic [LargeIdW-1:0]   large_id;
    logic [SegmentW-1:0]   segment;
    logic [WordW-1:0]      operand;
    logic [FenceDataW-1:0] fence_data;
  } res_t;

endpackage

// ===== hdl/icd_decode.sv =====
// Opcode decode and reserved-bit checks for one command word pair.
// Depends on icd_pkg.
module icd_decode (
  input  logic [icd_pkg::WordW-1:0] cmd_lo_i,
  input  logic [icd_pkg::WordW-1:0] cmd_hi_i,
  output icd_pkg::dec_t             dec_o
);
  import icd_pkg::*;

  logic [OpcodeW-1:0] op;
  logic [Func3W-1:0]  f3;
  logic               f3_first;
  logic               f3_second;

  assign op        = cmd_lo_i[6:0];
  assign f3        = cmd_lo_i[9:7];
  assign f3_first  = (f3 == F3First);
  assign f3_second = (f3 == F3Second);

  // Pick the group and apply its reserved-field and operand rules.
  always_comb begin
    dec_o.f3      = f3;
    dec_o.wis     = cmd_lo_i[13];
    dec_o.cls     = CLS_NONE;
    dec_o.rsv_ok  = 1'b0;
    dec_o.rule_ok = 1'b0;
    unique case (op)
      OpTinval: begin
        dec_o.cls     = CLS_TINVAL;
        dec_o.rsv_ok  = ~|{cmd_lo_i[15:13], cmd_lo_i[39:36], cmd_lo_i[63:56],
                           cmd_hi_i[63:52]};
        // A global invalidate must not carry a process context.
        dec_o.rule_ok = f3_first | (f3_second & ~cmd_lo_i[10]);
      end
      OpDir: begin
        dec_o.cls     = CLS_DIR;
        dec_o.rsv_ok  = ~|{cmd_lo_i[15:11], cmd_lo_i[39:36], cmd_lo_i[63:56],
                           cmd_hi_i};
        // Device-table invalidate takes no process id; process-table needs DV.
        dec_o.rule_ok = (f3_first & ~|cmd_lo_i[35:16]) | (f3_second & cmd_lo_i[10]);
      end
      OpFence: begin
        dec_o.cls     = CLS_FENCE;
        dec_o.rsv_ok  = ~|{cmd_lo_i[31:14], cmd_hi_i[1:0]};
        dec_o.rule_ok = f3_first;
      end
      OpAts: begin
        dec_o.cls     = CLS_ATS;
        dec_o.rsv_ok  = ~|{cmd_lo_i[39:36], cmd_lo_i[15:12]};
        dec_o.rule_ok = f3_first | f3_second;
      end
      default: begin
        dec_o.cls = CLS_NONE;
      end
    endcase
  end

endmodule

// ===== hdl/icd_legal.sv =====
// Final legality decision and kind assignment from the decode summary.
// Depends on icd_pkg.
module icd_legal (
  input  icd_pkg::dec_t dec_i,
  input  logic          wired_irq_i,
  output icd_pkg::kind_e kind_o
);
  import icd_pkg::*;

  logic legal;

  // A fence asking for a wired interrupt is refused when none is wired.
  assign legal = dec_i.rsv_ok & dec_i.rule_ok &
                 ~((dec_i.cls == CLS_FENCE) & dec_i.wis & ~wired_irq_i);

  // Map the group and function code onto the result kind.
  always_comb begin
    kind_o = KIND_ILLEGAL;
    if (legal) begin
      unique case (dec_i.cls)
        CLS_TINVAL: kind_o = dec_i.f3[0] ? KIND_GVMA : KIND_VMA;
        CLS_DIR:    kind_o = dec_i.f3[0] ? KIND_INVAL_PDT : KIND_INVAL_DDT;
        CLS_FENCE:  kind_o = KIND_FENCE;
        CLS_ATS:    kind_o = dec_i.f3[0] ? KIND_ATS_PRGR : KIND_ATS_INVAL;
        default:    kind_o = KIND_ILLEGAL;
      endcase
    end
  end

endmodule

// ===== hdl/icd_extract.sv =====
// Operand extraction per command kind; fields that do not apply are zero.
// Depends on icd_pkg.
module icd_extract (
  input  icd_pkg::kind_e            kind_i,
  input  logic [icd_pkg::WordW-1:0] cmd_lo_i,
  input  logic [icd_pkg::WordW-1:0] cmd_hi_i,
  output icd_pkg::res_t             res_o
);
  import icd_pkg::*;

  always_comb begin
    res_o            = '0;
    res_o.kind       = kind_i;
    unique case (kind_i)
      KIND_VMA, KIND_GVMA: begin
        res_o.flags    = {4'b0, cmd_lo_i[10], cmd_lo_i[11], cmd_lo_i[12]};
        res_o.small_id = cmd_lo_i[35:16];
        res_o.large_id = cmd_lo_i[55:40];
        res_o.operand  = {12'b0, cmd_hi_i[51:0]};
      end
      KIND_INVAL_DDT, KIND_INVAL_PDT: begin
        res_o.flags    = {3'b0, cmd_lo_i[10], 3'b0};
        res_o.small_id = cmd_lo_i[35:16];
        res_o.large_id = cmd_lo_i[55:40];
      end
      KIND_FENCE: begin
        res_o.flags      = {cmd_lo_i[13], cmd_lo_i[11], cmd_lo_i[10], 2'b0,
                            cmd_lo_i[12], 1'b0};
        res_o.operand    = cmd_hi_i;
        res_o.fence_data = cmd_lo_i[63:32];
      end
      KIND_ATS_INVAL, KIND_ATS_PRGR: begin
        res_o.flags    = {3'b0, cmd_lo_i[10], cmd_lo_i[11], 2'b0};
        res_o.small_id = cmd_lo_i[35:16];
        res_o.segment  = cmd_lo_i[47:40];
        res_o.large_id = cmd_lo_i[63:48];
        res_o.operand  = cmd_hi_i;
      end
      default: begin
        // Illegal command: kind only, every field zero.
        res_o.kind = KIND_ILLEGAL;
      end
    endcase
  end

endmodule

// ===== hdl/iommu_command_decode.sv =====
// Top level of the IOMMU command decoder: three-stage pipeline and stream ports.
// Depends on icd_pkg, icd_decode, icd_legal and icd_extract.
//
//   Channel  | Direction | Contents
//   s_axis   | in        | tdata = command_low[63:0], command_high[127:64]
//   m_axis   | out       | tuser = kind; tdata = flags .. fence_data
//   cfg      | in        | wired_irq_supported, written when cfg_we_i is high
//
// Each request passes three register stages: decode, legality, extraction.
// A result passes the decode, legality and extraction registers before it is valid
// on m_axis; one request can be taken every cycle unless a stall on m_axis has
// filled the stages. Reset clears the stage valid bits and the register.
// A stall on m_axis holds each stage only while the stage ahead is full, so
// bubbles are squeezed out and nothing is dropped or repeated.
module iommu_command_decode (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i,
  // Command input
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [63:0] command_low, [127:64] command_high
  input  logic [icd_pkg::InDataW-1:0]   s_axis_tdata,
  // Result output
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [6:0] flags, [26:7] small_id, [42:27] large_id, [50:43] segment,
  // [114:51] operand, [146:115] fence_data, [151:147] zero
  output logic [icd_pkg::OutDataW-1:0]  m_axis_tdata,
  // [2:0] kind
  output logic [icd_pkg::KindW-1:0]     m_axis_tuser
);
  import icd_pkg::*;

  logic             wired_irq_q;
  logic             v1_q, v2_q, v3_q;
  logic             adv1, adv2, adv3;
  logic [WordW-1:0] lo1_q, hi1_q, lo2_q, hi2_q;
  dec_t             dec_d, dec1_q;
  kind_e            kind_d, kind2_q;
  res_t             res_d, res3_q;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wired_irq_q <= 1'b0;
    end else if (cfg_we_i) begin
      wired_irq_q <= cfg_wdata_i;
    end
  end

  // A stage moves when it is empty or the stage ahead moves.
  assign adv3          = ~v3_q | m_axis_tready;
  assign adv2          = ~v2_q | adv3;
  assign adv1          = ~v1_q | adv2;
  assign s_axis_tready = adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= s_axis_tvalid;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
    end
  end

  // Stage one: opcode decode and reserved-bit checks.
  icd_decode u_decode (
    .cmd_lo_i (s_axis_tdata[63:0]),
    .cmd_hi_i (s_axis_tdata[127:64]),
    .dec_o    (dec_d)
  );

  always_ff @(posedge clk_i) begin
    if (adv1 && s_axis_tvalid) begin
      dec1_q <= dec_d;
      lo1_q  <= s_axis_tdata[63:0];
      hi1_q  <= s_axis_tdata[127:64];
    end
  end

  // Stage two: legality and kind.
  icd_legal u_legal (
    .dec_i       (dec1_q),
    .wired_irq_i (wired_irq_q),
    .kind_o      (kind_d)
  );

  always_ff @(posedge clk_i) begin
    if (adv2 && v1_q) begin
      kind2_q <= kind_d;
      lo2_q   <= lo1_q;
      hi2_q   <= hi1_q;
    end
  end

  // Stage three: field extraction into the output register.
  icd_extract u_extract (
    .kind_i   (kind2_q),
    .cmd_lo_i (lo2_q),
    .cmd_hi_i (hi2_q),
    .res_o    (res_d)
  );

  always_ff @(posedge clk_i) begin
    if (adv3 && v2_q) begin
      res3_q <= res_d;
    end
  end

  // Output packing.
  assign m_axis_tvalid = v3_q;
  assign m_axis_tuser  = res3_q.kind;
  assign m_axis_tdata  = {5'b0, res3_q.fence_data, res3_q.operand, res3_q.segment,
                          res3_q.large_id, res3_q.small_id, res3_q.flags};

endmodule

// ===== test/icd_checker.sv =====
// Checker for the IOMMU command decoder: watches both streams and the config port.
// Predicts each result from the accepted command and compares it field by field.
// Depends on icd_pkg for the opcodes, the kind codes and the result struct.
module icd_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_wdata_i,
  input  logic                         cmd_valid_i,
  input  logic                         cmd_ready_i,
  // [63:0] command_low, [127:64] command_high
  input  logic [icd_pkg::InDataW-1:0]  cmd_data_i,
  input  logic                         res_valid_i,
  input  logic                         res_ready_i,
  // [6:0] flags, [26:7] small_id, [42:27] large_id, [50:43] segment,
  // [114:51] operand, [146:115] fence_data, [151:147] zero
  input  logic [icd_pkg::OutDataW-1:0] res_data_i,
  // [2:0] kind
  input  logic [icd_pkg::KindW-1:0]    res_kind_i,
  output int                           fail_count_o,
  output int                           pending_o
);
  import icd_pkg::*;

  logic wis_allowed;
  res_t decoded_commands[$];
  res_t want;
  int   mismatches = 0;

  assign fail_count_o = mismatches;

  // Decode of one command as the block should see it.
  function automatic res_t decode_command(input logic [63:0] lo, input logic [63:0] hi,
                                          input logic wis_ok);
    res_t                r;
    logic                legal;
    logic [OpcodeW-1:0]  op;
    logic [Func3W-1:0]   f3;
    r     = '0;
    legal = 1'b0;
    op    = lo[6:0];
    f3    = lo[9:7];
    case (op)
      OpTinval: begin
        // PSCV is not allowed with a guest-wide invalidate.
        if (lo[15:13] == '0 && lo[39:36] == '0 && lo[63:56] == '0 && hi[63:52] == '0 &&
            (f3 == F3First || (f3 == F3Second && !lo[10]))) begin
          legal      = 1'b1;
          r.kind     = (f3 == F3First) ? KIND_VMA : KIND_GVMA;
          r.flags    = {4'b0, lo[10], lo[11], lo[12]};
          r.small_id = lo[35:16];
          r.large_id = lo[55:40];
          r.operand  = {12'b0, hi[51:0]};
        end
      end
      OpDir: begin
        // Device directory invalidates take no PID; process ones need DV.
        if (lo[15:11] == '0 && lo[39:36] == '0 && lo[63:56] == '0 && hi == '0 &&
            ((f3 == F3First && lo[35:16] == '0) || (f3 == F3Second && lo[10]))) begin
          legal      = 1'b1;
          r.kind     = (f3 == F3First) ? KIND_INVAL_DDT : KIND_INVAL_PDT;
          r.flags    = {3'b0, lo[10], 3'b0};
          r.small_id = lo[35:16];
          r.large_id = lo[55:40];
        end
      end
      OpFence: begin
        // The wired interrupt bit is legal only when the register permits it.
        if (lo[31:14] == '0 && hi[1:0] == '0 && f3 == F3First && (wis_ok || !lo[13])) begin
          legal        = 1'b1;
          r.kind       = KIND_FENCE;
          r.flags      = {lo[13], lo[11], lo[10], 2'b0, lo[12], 1'b0};
          r.operand    = hi;
          r.fence_data = lo[63:32];
        end
      end
      OpAts: begin
        if (lo[39:36] == '0 && lo[15:12] == '0 && (f3 == F3First || f3 == F3Second)) begin
          legal      = 1'b1;
          r.kind     = (f3 == F3First) ? KIND_ATS_INVAL : KIND_ATS_PRGR;
          r.flags    = {3'b0, lo[10], lo[11], 2'b0};
          r.small_id = lo[35:16];
          r.segment  = lo[47:40];
          r.large_id = lo[63:48];
          r.operand  = hi;
        end
      end
      default: legal = 1'b0;
    endcase
    // An illegal command carries nothing but its kind.
    if (!legal) begin
      r      = '0;
      r.kind = KIND_ILLEGAL;
    end
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [63:0] exp_val,
                               input logic [63:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t icd_checker: %s expected %h actual %h", $time, name, exp_val, act_val);
      mismatches++;
    end
  endtask

  // Track the register, queue a prediction per request, check each result.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wis_allowed <= 1'b0;
      decoded_commands.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        wis_allowed <= cfg_wdata_i;
      end
      if (cmd_valid_i && cmd_ready_i) begin
        decoded_commands.push_back(decode_command(cmd_data_i[63:0], cmd_data_i[127:64],
                                                  wis_allowed));
      end
      if (res_valid_i && res_ready_i) begin
        if (decoded_commands.size() == 0) begin
          $display("%0t icd_checker: result kind %0d with no request outstanding",
                   $time, res_kind_i);
          mismatches++;
        end else begin
          want = decoded_commands.pop_front();
          compare_field("kind", 64'(want.kind), 64'(res_kind_i));
          compare_field("flags", 64'(want.flags), 64'(res_data_i[6:0]));
          compare_field("small_id", 64'(want.small_id), 64'(res_data_i[26:7]));
          compare_field("large_id", 64'(want.large_id), 64'(res_data_i[42:27]));
          compare_field("segment", 64'(want.segment), 64'(res_data_i[50:43]));
          compare_field("operand", want.operand, res_data_i[114:51]);
          compare_field("fence_data", 64'(want.fence_data), 64'(res_data_i[146:115]));
          compare_field("padding", 64'd0, 64'(res_data_i[151:147]));
        end
      end
      pending_o <= decoded_commands.size();
    end
  end

endmodule

// ===== test/tb.sv =====
// Top of the IOMMU command decoder testbench: clock, reset, commands and verdict.
// Depends on icd_pkg, the decoder iommu_command_decode and the checker icd_checker.
module tb;
  import icd_pkg::*;

  // Reserved bits of each command group.
  localparam logic [63:0] TinvalLoRsv = 64'hFF00_00F0_0000_E000;
  localparam logic [63:0] TinvalHiRsv = 64'hFFF0_0000_0000_0000;
  localparam logic [63:0] DirLoRsv    = 64'hFF00_00F0_0000_F800;
  localparam logic [63:0] FenceLoRsv  = 64'h0000_0000_FFFF_C000;
  localparam logic [63:0] FenceHiRsv  = 64'h0000_0000_0000_0003;
  localparam logic [63:0] AtsLoRsv    = 64'h0000_00F0_0000_F000;
  // Operand bits that carry special rules.
  localparam logic [63:0] LoBit10     = 64'h0000_0000_0000_0400;
  localparam logic [63:0] WisBit      = 64'h0000_0000_0000_2000;
  localparam logic [63:0] PidMask     = 64'h0000_000F_FFFF_0000;
  // Codes that no command uses.
  localparam logic [OpcodeW-1:0] OpUnknown = 7'd5;
  localparam logic [OpcodeW-1:0] OpTop     = 7'h7F;
  localparam logic [Func3W-1:0]  F3Unused  = 3'd2;

  localparam int PhaseItems = 150;
  localparam int IdleLimit  = 2000;
  localparam int DrainWait  = 8;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic                cfg_wdata_i = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [KindW-1:0]    m_axis_tuser;

  int fail_count;
  int pending_count;
  int gap_pct = 0;
  int stall_pct = 0;
  int idle_cycles = 0;

  int phase_gap[4]   = '{0, 63, 0, 33};
  int phase_stall[4] = '{0, 0, 63, 33};
  int phase_wis[4]   = '{0, 1, 0, 1};

  always #4 clk_i = ~clk_i;

  iommu_command_decode u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  icd_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .cmd_valid_i  (s_axis_tvalid),
    .cmd_ready_i  (s_axis_tready),
    .cmd_data_i   (s_axis_tdata),
    .res_valid_i  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_data_i   (m_axis_tdata),
    .res_kind_i   (m_axis_tuser),
    .fail_count_o (fail_count),
    .pending_o    (pending_count)
  );

  // The result side stalls at random according to the current phase.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // End the run when no request moves on either side for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [63:0] with_code(input logic [63:0] body,
                                            input logic [OpcodeW-1:0] op,
                                            input logic [Func3W-1:0] f3);
    return {body[63:10], f3, op};
  endfunction

  // Offer one command and hold it until the decoder takes it.
  task automatic push_command(input logic [63:0] lo, input logic [63:0] hi);
    while ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {hi, lo};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Wait until every predicted result has been delivered, then let the pipe settle.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_count != 0);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_wired_irq(input logic value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Mostly well-formed commands of a random kind, some with a broken rule or a
  // flipped bit, and a little pure noise.
  task automatic make_command(output logic [63:0] lo, output logic [63:0] hi);
    int unsigned        shape;
    int unsigned        pick;
    logic [OpcodeW-1:0] op_any;
    logic [Func3W-1:0]  f3_any;
    logic [5:0]         bit_sel;
    lo     = {$urandom, $urandom};
    hi     = {$urandom, $urandom};
    shape  = $urandom_range(99);
    pick   = $urandom_range(6);
    op_any = OpcodeW'($urandom_range(OpAts));
    f3_any = Func3W'($urandom_range(3));
    if (shape < 90) begin
      case (pick)
        0: begin
          lo = with_code(lo & ~TinvalLoRsv, OpTinval, F3First);
          hi = hi & ~TinvalHiRsv;
        end
        1: begin
          lo = with_code(lo & ~TinvalLoRsv & ~LoBit10, OpTinval, F3Second);
          hi = hi & ~TinvalHiRsv;
        end
        2: begin
          lo = with_code(lo & ~DirLoRsv & ~PidMask, OpDir, F3First);
          hi = '0;
        end
        3: begin
          lo = with_code((lo & ~DirLoRsv) | LoBit10, OpDir, F3Second);
          hi = '0;
        end
        4: begin
          lo = with_code(lo & ~FenceLoRsv, OpFence, F3First);
          hi = hi & ~FenceHiRsv;
        end
        default: begin
          lo = with_code(lo & ~AtsLoRsv, OpAts, (pick == 5) ? F3First : F3Second);
        end
      endcase
      if (shape >= 70 && shape < 80) begin
        // Break the rule that belongs to this kind.
        case (pick)
          1:       lo = lo | LoBit10;
          2:       lo[6'($urandom_range(35, 16))] = 1'b1;
          3:       lo = lo & ~LoBit10;
          4:       lo = lo | WisBit;
          default: lo[6'($urandom_range(9, 7))] = 1'b1;
        endcase
      end else if (shape >= 80) begin
        bit_sel = 6'($urandom_range(63));
        if ($urandom_range(1) == 0) begin
          lo[bit_sel] = ~lo[bit_sel];
        end else begin
          hi[bit_sel] = ~hi[bit_sel];
        end
      end
    end else if (shape < 95) begin
      lo = with_code(lo, op_any, f3_any);
    end
  endtask

  initial begin
    logic [63:0] lo;
    logic [63:0] hi;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed commands with the register at its reset value.
    push_command('0, '0);
    push_command('1, '1);
    push_command(with_code('0, OpTinval, F3First), '0);
    push_command(with_code(~TinvalLoRsv, OpTinval, F3First), ~TinvalHiRsv);
    push_command(with_code(~TinvalLoRsv & ~LoBit10, OpTinval, F3Second), ~TinvalHiRsv);
    // Guest-wide invalidate with PSCV set.
    push_command(with_code(LoBit10, OpTinval, F3Second), '0);
    push_command(with_code('0, OpTinval, F3First), 64'h0010_0000_0000_0000);
    push_command(with_code('0, OpTinval, F3Unused), '0);
    push_command(with_code(~DirLoRsv & ~PidMask, OpDir, F3First), '0);
    // Device directory invalidate with a nonzero PID.
    push_command(with_code(64'h0000_0000_0001_0000, OpDir, F3First), '0);
    push_command(with_code('0, OpDir, F3First), 64'h8000_0000_0000_0000);
    push_command(with_code(~DirLoRsv, OpDir, F3Second), '0);
    // Process directory invalidate with DV clear.
    push_command(with_code(~DirLoRsv & ~LoBit10, OpDir, F3Second), '0);
    push_command(with_code('0, OpFence, F3First), '0);
    push_command(with_code(~FenceLoRsv & ~WisBit, OpFence, F3First), ~FenceHiRsv);
    // Fence asking for a wired interrupt that is not supported.
    push_command(with_code(WisBit, OpFence, F3First), '0);
    push_command(with_code('0, OpFence, F3Second), '0);
    push_command(with_code('0, OpFence, F3First), 64'h1);
    push_command(with_code(~AtsLoRsv, OpAts, F3First), '1);
    push_command(with_code(~AtsLoRsv, OpAts, F3Second), '1);
    push_command(with_code('0, OpAts, F3Unused), '0);
    push_command(with_code('0, OpUnknown, F3First), '0);
    push_command(with_code('0, OpTop, F3First), '0);
    drain_results();

    // The same fences once wired interrupts are supported.
    write_wired_irq(1'b1);
    push_command(with_code(WisBit, OpFence, F3First), '0);
    push_command(with_code(~FenceLoRsv, OpFence, F3First), '1);
    drain_results();

    // Random phases with different idling and register settings.
    for (int phase = 0; phase < 4; phase++) begin
      write_wired_irq(phase_wis[phase][0]);
      gap_pct   = phase_gap[phase];
      stall_pct = phase_stall[phase];
      for (int n = 0; n < PhaseItems; n++) begin
        make_command(lo, hi);
        push_command(lo, hi);
        // Now and then hold the sender until the pipe is empty.
        if ($urandom_range(99) == 0) begin
          drain_results();
        end
      end
      drain_results();
    end

    if (fail_count == 0 && pending_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/icd_pkg.sv
hdl/icd_decode.sv
hdl/icd_legal.sv
hdl/icd_extract.sv
hdl/iommu_command_decode.sv
test/icd_checker.sv
test/tb.sv
